>>> hdl/cdtp_pkg.sv
// ----------------------------------------------------------------------------
// cdtp_pkg
// Shared types and constants of the canonical decimal text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cdtp_pkg;

    localparam int unsigned MAX_DIGITS = 20;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned CODE_W     = 3;

    localparam logic [COUNT_W-1:0] COUNT_CAP   = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_DIGITS);

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    typedef enum logic [CODE_W-1:0] {
        FAIL_OK        = 3'd0,
        FAIL_EMPTY     = 3'd1,
        FAIL_TOO_LONG  = 3'd2,
        FAIL_LEAD_ZERO = 3'd3,
        FAIL_NON_DIGIT = 3'd4,
        FAIL_OVERFLOW  = 3'd5,
        FAIL_ABOVE_MAX = 3'd6
    } fail_code_t;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              end_of_text;
        logic              no_char;
    } char_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic               first_zero;
        fail_code_t         fault;
    } text_state_t;

endpackage

`default_nettype wire

>>> hdl/cdtp_in_stage.sv
// ----------------------------------------------------------------------------
// cdtp_in_stage
// Input register: holds one character item until the datapath takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cdtp_in_stage (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [cdtp_pkg::CHAR_W-1:0] s_text_char,
    input  wire logic                       s_end_of_text,
    input  wire logic                       s_no_char,
    input  wire logic                       advance,
    output logic                            item_valid,
    output cdtp_pkg::char_item_t            item
);
    import cdtp_pkg::*;

    logic       valid_reg;
    char_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.text_char   <= s_text_char;
            item_reg.end_of_text <= s_end_of_text;
            item_reg.no_char     <= s_no_char;
        end
    end

    property p_advance_needs_item;
        @(posedge aclk) disable iff (!aresetn)
        advance |-> valid_reg;
    endproperty
    a_advance_needs_item: assert property (p_advance_needs_item)
        else $error("datapath advanced with an empty input register");

    property p_full_holds;
        @(posedge aclk) disable iff (!aresetn)
        (valid_reg && !advance) |=> (valid_reg && item_reg == $past(item_reg));
    endproperty
    a_full_holds: assert property (p_full_holds)
        else $error("held item changed while stalled");

    property p_not_ready_when_empty;
        @(posedge aclk) disable iff (!aresetn)
        !valid_reg |-> s_ready;
    endproperty
    a_not_ready_when_empty: assert property (p_not_ready_when_empty)
        else $error("input stalled with an empty register");

endmodule

`default_nettype wire

>>> hdl/cdtp_accum.sv
// ----------------------------------------------------------------------------
// cdtp_accum
// Running text state: value, character count, leading-zero mark and first
// fault, updated by one character per cycle while advance is high.
// ----------------------------------------------------------------------------
`default_nettype none

module cdtp_accum (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  advance,
    input  wire cdtp_pkg::char_item_t  item,
    output cdtp_pkg::text_state_t      after_state
);
    import cdtp_pkg::*;

    text_state_t           state_reg;
    text_state_t           state_next;
    text_state_t           stepped;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [VALUE_W+3:0]    product;

    assign is_digit = (item.text_char >= CHAR_ZERO) && (item.text_char <= CHAR_NINE);
    assign digit    = item.text_char[3:0];
    assign product  = ({4'b0, state_reg.value} << 3) + ({4'b0, state_reg.value} << 1)
                    + {{VALUE_W{1'b0}}, digit};

    always_comb begin
        stepped = state_reg;
        if (state_reg.count == '0 && item.text_char == CHAR_ZERO) begin
            stepped.first_zero = 1'b1;
        end
        if (state_reg.count != COUNT_CAP) begin
            stepped.count = state_reg.count + COUNT_W'(1);
        end
        if (state_reg.fault == FAIL_OK) begin
            if (!is_digit) begin
                stepped.fault = FAIL_NON_DIGIT;
            end else if (product[VALUE_W+3:VALUE_W] != 4'b0) begin
                stepped.fault = FAIL_OVERFLOW;
            end else begin
                stepped.value = product[VALUE_W-1:0];
            end
        end
    end

    assign after_state = item.no_char ? state_reg : stepped;

    always_comb begin
        state_next = state_reg;
        if (advance) begin
            state_next = item.end_of_text ? '0 : after_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    property p_fault_sticks;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg.fault != FAIL_OK && !(advance && item.end_of_text))
            |=> (state_reg.fault == $past(state_reg.fault)
                 && state_reg.value == $past(state_reg.value));
    endproperty
    a_fault_sticks: assert property (p_fault_sticks)
        else $error("value or fault moved after a fault");

    property p_count_grows;
        @(posedge aclk) disable iff (!aresetn)
        !(advance && item.end_of_text) |=> state_reg.count >= $past(state_reg.count);
    endproperty
    a_count_grows: assert property (p_count_grows)
        else $error("character count fell within a text");

    property p_fault_kind;
        @(posedge aclk) disable iff (!aresetn)
        state_reg.fault == FAIL_OK || state_reg.fault == FAIL_NON_DIGIT
            || state_reg.fault == FAIL_OVERFLOW;
    endproperty
    a_fault_kind: assert property (p_fault_kind)
        else $error("running fault is neither non-digit nor overflow");

endmodule

`default_nettype wire

>>> hdl/cdtp_result.sv
// ----------------------------------------------------------------------------
// cdtp_result
// Verdict on a finished text and the result register, plus the max_accepted
// configuration register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdtp_result (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [cdtp_pkg::VALUE_W-1:0] cfg_max_accepted,
    input  wire logic                         load,
    input  wire cdtp_pkg::text_state_t        final_state,
    output logic                              slot_free,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_accepted,
    output logic [cdtp_pkg::VALUE_W-1:0]      m_parsed_value,
    output logic [cdtp_pkg::CODE_W-1:0]       m_fail_code
);
    import cdtp_pkg::*;

    logic [VALUE_W-1:0] max_reg;
    logic               valid_reg;
    logic               ok_reg;
    logic [VALUE_W-1:0] value_reg;
    fail_code_t         code_reg;
    fail_code_t         code_next;

    assign cfg_ready = 1'b1;
    assign slot_free = !valid_reg || m_ready;

    always_comb begin
        if (final_state.count == '0) begin
            code_next = FAIL_EMPTY;
        end else if (final_state.count > COUNT_LIMIT) begin
            code_next = FAIL_TOO_LONG;
        end else if (final_state.count > COUNT_W'(1) && final_state.first_zero) begin
            code_next = FAIL_LEAD_ZERO;
        end else if (final_state.fault != FAIL_OK) begin
            code_next = final_state.fault;
        end else if (final_state.value > max_reg) begin
            code_next = FAIL_ABOVE_MAX;
        end else begin
            code_next = FAIL_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= {VALUE_W{1'b1}};
        end else if (cfg_valid && cfg_ready) begin
            max_reg <= cfg_max_accepted;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (slot_free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && slot_free) begin
            ok_reg    <= (code_next == FAIL_OK);
            value_reg <= (code_next == FAIL_OK) ? final_state.value : '0;
            code_reg  <= code_next;
        end
    end

    assign m_valid        = valid_reg;
    assign m_accepted     = ok_reg;
    assign m_parsed_value = value_reg;
    assign m_fail_code    = code_reg;

    property p_ok_matches_code;
        @(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (ok_reg == (code_reg == FAIL_OK));
    endproperty
    a_ok_matches_code: assert property (p_ok_matches_code)
        else $error("ok flag disagrees with fail code");

    property p_reject_zero_value;
        @(posedge aclk) disable iff (!aresetn)
        (valid_reg && !ok_reg) |-> value_reg == '0;
    endproperty
    a_reject_zero_value: assert property (p_reject_zero_value)
        else $error("rejected text carries a value");

    property p_ok_within_max;
        @(posedge aclk) disable iff (!aresetn)
        (valid_reg && ok_reg && !$past(cfg_valid)) |-> value_reg <= max_reg;
    endproperty
    a_ok_within_max: assert property (p_ok_within_max)
        else $error("accepted value above max_accepted");

endmodule

`default_nettype wire

>>> hdl/canonical_decimal_text_parser_top.sv
// ----------------------------------------------------------------------------
// canonical_decimal_text_parser_top
// Parses canonical unsigned decimal ASCII text into a 64-bit value.
//
// Input channel (s_): one character item per handshake; s_end_of_text marks
// the last item of a text, s_no_char marks an item with no character (closes
// an empty text when also last). Result channel (m_): one item per text,
// carrying ok flag, value (zero when rejected) and fail code.
// Configuration channel (cfg_): writes max_accepted; always ready. Write only
// while no text is in flight.
// Throughput: one character per cycle, except that a last item waits while the
// result register is full; set by the combinational multiply-by-ten-and-add.
// Path: after its last character is taken, a result passes the input register,
// then the result register; it waits longer only while the result register
// still holds an earlier result.
// Reset: clears the running text state and both registers' valid bits;
// max_accepted returns to all ones.
// Stall: a waiting result holds; characters keep flowing until a last item
// reaches the datapath, which then waits in the input register and drops
// s_ready until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module canonical_decimal_text_parser_top (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [cdtp_pkg::CHAR_W-1:0]  s_text_char,
    input  wire logic                         s_end_of_text,
    input  wire logic                         s_no_char,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_accepted,
    output logic [cdtp_pkg::VALUE_W-1:0]      m_parsed_value,
    output logic [cdtp_pkg::CODE_W-1:0]       m_fail_code,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [cdtp_pkg::VALUE_W-1:0] cfg_max_accepted
);
    import cdtp_pkg::*;

    logic        item_valid;
    char_item_t  item;
    logic        advance;
    logic        slot_free;
    text_state_t after_state;

    assign advance = item_valid && (!item.end_of_text || slot_free);

    cdtp_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_char   (s_text_char),
        .s_end_of_text (s_end_of_text),
        .s_no_char     (s_no_char),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    cdtp_accum u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .item        (item),
        .after_state (after_state)
    );

    cdtp_result u_result (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_max_accepted (cfg_max_accepted),
        .load             (advance && item.end_of_text),
        .final_state      (after_state),
        .slot_free        (slot_free),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_accepted       (m_accepted),
        .m_parsed_value   (m_parsed_value),
        .m_fail_code      (m_fail_code)
    );

    property p_last_waits_for_slot;
        @(posedge aclk) disable iff (!aresetn)
        (item_valid && item.end_of_text && !slot_free) |=> item_valid;
    endproperty
    a_last_waits_for_slot: assert property (p_last_waits_for_slot)
        else $error("last item dropped while result slot was full");

    property p_result_follows_last;
        @(posedge aclk) disable iff (!aresetn)
        (advance && item.end_of_text) |=> m_valid;
    endproperty
    a_result_follows_last: assert property (p_result_follows_last)
        else $error("finished text produced no result");

    property p_plain_char_flows;
        @(posedge aclk) disable iff (!aresetn)
        (item_valid && !item.end_of_text) |-> s_ready;
    endproperty
    a_plain_char_flows: assert property (p_plain_char_flows)
        else $error("input stalled behind a non-final character");

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the canonical decimal text parser. A queue-fed
// driver sends character items and predicts each text's result on
// acceptance. A monitor compares every result item with the oldest
// prediction. Both sides idle at random. max_accepted is rewritten between
// phases, once the parser is idle.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cdtp_pkg::*;

    localparam logic [VALUE_W-1:0] ALL_ONES     = {VALUE_W{1'b1}};
    localparam int                 PHASE_ITEMS  = 217;
    localparam int                 SETTLE_TICKS = 4;

    typedef struct packed {
        logic               accepted;
        logic [VALUE_W-1:0] value;
        fail_code_t         code;
    } parse_result_t;

    logic               aclk             = 1'b0;
    logic               aresetn          = 1'b0;
    logic               s_valid          = 1'b0;
    logic               s_ready;
    logic [CHAR_W-1:0]  s_text_char      = '0;
    logic               s_end_of_text    = 1'b0;
    logic               s_no_char        = 1'b0;
    logic               m_valid;
    logic               m_ready          = 1'b0;
    logic               m_accepted;
    logic [VALUE_W-1:0] m_parsed_value;
    logic [CODE_W-1:0]  m_fail_code;
    logic               cfg_valid        = 1'b0;
    logic               cfg_ready;
    logic [VALUE_W-1:0] cfg_max_accepted = ALL_ONES;

    char_item_t    char_feed[$];
    parse_result_t results_due[$];
    parse_result_t want;

    logic [VALUE_W-1:0] max_accepted_model = ALL_ONES;
    logic [VALUE_W-1:0] run_value          = '0;
    logic [COUNT_W-1:0] run_count          = '0;
    logic               run_first_zero     = 1'b0;
    fail_code_t         run_fault          = FAIL_OK;

    int  mismatches   = 0;
    int  random_items = 0;
    int  send_gap     = 0;
    int  recv_stall   = 0;
    bit  send_idle_on = 1'b1;
    bit  recv_idle_on = 1'b1;

    canonical_decimal_text_parser_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_text_char      (s_text_char),
        .s_end_of_text    (s_end_of_text),
        .s_no_char        (s_no_char),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_accepted       (m_accepted),
        .m_parsed_value   (m_parsed_value),
        .m_fail_code      (m_fail_code),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_max_accepted (cfg_max_accepted)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void parse_char(char_item_t it);
        logic [VALUE_W-1:0] digit;
        fail_code_t         code;
        parse_result_t      res;
        if (!it.no_char) begin
            if (run_count == '0 && it.text_char == CHAR_ZERO) run_first_zero = 1'b1;
            if (run_count != COUNT_CAP) run_count = run_count + 1'b1;
            if (run_fault == FAIL_OK) begin
                if (it.text_char < CHAR_ZERO || it.text_char > CHAR_NINE) begin
                    run_fault = FAIL_NON_DIGIT;
                end else begin
                    digit = VALUE_W'(it.text_char - CHAR_ZERO);
                    if (run_value > (ALL_ONES - digit) / 10) begin
                        run_fault = FAIL_OVERFLOW;
                    end else begin
                        run_value = run_value * 10 + digit;
                    end
                end
            end
        end
        if (it.end_of_text) begin
            if (run_count == '0) code = FAIL_EMPTY;
            else if (run_count > COUNT_LIMIT) code = FAIL_TOO_LONG;
            else if (run_count > 1 && run_first_zero) code = FAIL_LEAD_ZERO;
            else if (run_fault != FAIL_OK) code = run_fault;
            else if (run_value > max_accepted_model) code = FAIL_ABOVE_MAX;
            else code = FAIL_OK;
            res.accepted = (code == FAIL_OK);
            res.value    = (code == FAIL_OK) ? run_value : '0;
            res.code     = code;
            results_due.insert(results_due.size(), res);
            run_value      = '0;
            run_count      = '0;
            run_first_zero = 1'b0;
            run_fault      = FAIL_OK;
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) parse_char({s_text_char, s_end_of_text, s_no_char});
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (char_feed.size() != 0) begin
                    {s_text_char, s_end_of_text, s_no_char} <= char_feed.pop_front();
                    s_valid <= 1'b1;
                    if (send_idle_on) send_gap = idle_span();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result item: accepted %0d value %0d code %0d",
                             $time, m_accepted, m_parsed_value, m_fail_code);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (m_accepted !== want.accepted) begin
                        $display("%0t: accepted expected %0d actual %0d",
                                 $time, want.accepted, m_accepted);
                        mismatches++;
                    end
                    if (m_parsed_value !== want.value) begin
                        $display("%0t: parsed_value expected %0d actual %0d",
                                 $time, want.value, m_parsed_value);
                        mismatches++;
                    end
                    if (m_fail_code !== want.code) begin
                        $display("%0t: fail_code expected %0d actual %0d",
                                 $time, want.code, m_fail_code);
                        mismatches++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (recv_idle_on) recv_stall = idle_span();
            end
        end
    end

    task automatic push_item(input logic [CHAR_W-1:0] c, input logic last, input logic none);
        char_item_t it;
        it.text_char   = c;
        it.end_of_text = last;
        it.no_char     = none;
        char_feed.insert(char_feed.size(), it);
    endtask

    task automatic push_digits(input string s);
        for (int i = 0; i < s.len(); i++) push_item(s[i], i == s.len() - 1, 1'b0);
    endtask

    task automatic queue_random_text();
        logic [CHAR_W-1:0]  body[$];
        logic [CHAR_W-1:0]  c;
        logic [VALUE_W-1:0] v;
        int                 kind;
        int                 variant;
        int                 len;
        int                 pos;
        bit                 tail_none;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
            body.insert(body.size(), CHAR_ZERO + CHAR_W'($urandom_range(1, 9)));
            repeat (len - 1) body.insert(body.size(), CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
            if (len == 1 && $urandom_range(0, 3) == 0) body[0] = CHAR_ZERO;
        end else if (kind < 52) begin
            variant = $urandom_range(0, 3);
            case (variant)
                0: v = {$urandom, $urandom};
                1: v = ALL_ONES - VALUE_W'($urandom_range(0, 3));
                2: v = max_accepted_model + VALUE_W'($urandom_range(0, 2)) - 1'b1;
                default: v = ALL_ONES;
            endcase
            do begin
                body.push_front(CHAR_ZERO + CHAR_W'(v % 10));
                v = v / 10;
            end while (v != 0);
            // push just past the 64-bit range
            if (variant == 3) body[body.size() - 1] = CHAR_ZERO + CHAR_W'($urandom_range(6, 9));
        end else if (kind < 60) begin
            body.insert(body.size(), CHAR_ZERO);
            repeat ($urandom_range(1, 5))
                body.insert(body.size(), CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
        end else if (kind < 72) begin
            len = $urandom_range(1, 8);
            repeat (len) body.insert(body.size(), CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
            if (body[0] == CHAR_ZERO) body[0] = CHAR_NINE;
            do c = CHAR_W'($urandom_range(0, 255)); while (c >= CHAR_ZERO && c <= CHAR_NINE);
            pos = $urandom_range(0, len - 1);
            body[pos] = c;
        end else if (kind < 80) begin
            len = $urandom_range(21, 40);
            repeat (len) body.insert(body.size(), CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
            if ($urandom_range(0, 3) == 0) body[$urandom_range(0, len - 1)] = CHAR_W'($urandom);
        end else if (kind >= 86) begin
            repeat ($urandom_range(1, 6)) body.insert(body.size(), CHAR_W'($urandom_range(0, 255)));
        end
        tail_none = ($urandom_range(0, 6) == 0);
        foreach (body[i]) begin
            if ($urandom_range(0, 9) == 0) begin
                push_item(CHAR_W'($urandom), 1'b0, 1'b1);
                random_items++;
            end
            push_item(body[i], (i == body.size() - 1) && !tail_none, 1'b0);
        end
        if (body.size() == 0 || tail_none) begin
            push_item(CHAR_W'($urandom), 1'b1, 1'b1);
            random_items++;
        end
        random_items += body.size();
    endtask

    // hold until every item is sent and every result is back, then let it settle
    task automatic settle();
        do @(negedge aclk); while (char_feed.size() != 0 || s_valid || results_due.size() != 0);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_max_accepted(input logic [VALUE_W-1:0] v);
        settle();
        cfg_valid        <= 1'b1;
        cfg_max_accepted <= v;
        do @(posedge aclk); while (!cfg_ready);
        max_accepted_model = v;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        push_item(CHAR_W'($urandom), 1'b1, 1'b1);
        push_digits("0");
        push_digits("9");
        push_digits("05");
        push_digits("1x");
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(CHAR_ZERO - 1'b1, 1'b1, 1'b0);
        push_item(CHAR_NINE + 1'b1, 1'b1, 1'b0);
        push_item(CHAR_W'($urandom), 1'b0, 1'b1);
        push_digits("3");
        push_item(CHAR_ZERO + 8'd4, 1'b0, 1'b0);
        push_item(CHAR_ZERO + 8'd2, 1'b0, 1'b0);
        push_item(CHAR_W'($urandom), 1'b1, 1'b1);
        push_digits("10");

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_max_accepted('0);
                1: write_max_accepted(VALUE_W'($urandom_range(0, 99999)));
                2: write_max_accepted({$urandom, $urandom});
                3: write_max_accepted({1'b1, {(VALUE_W-1){1'b0}}});
                4: write_max_accepted(ALL_ONES - VALUE_W'($urandom_range(1, 9)));
                default: write_max_accepted(ALL_ONES);
            endcase
            send_idle_on = !(phase == 1 || phase == 3);
            recv_idle_on = !(phase == 1 || phase == 4);
            random_items = 0;
            while (random_items < PHASE_ITEMS) queue_random_text();
        end

        settle();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
